/* hw/rtl/urxpd_pkg.sv */
package urxpd_pkg;

	localparam int QUEUE_DEPTH_DEF = 1024;
	localparam int NUM_PORTS_DEF   = 4;
	localparam int PHRASE_LEN_DEF  = 29;

	localparam int PORT_W      = 2;
	localparam int MASK_W      = 4;
	localparam int MATCH_W     = 5;
	localparam int CNT_W       = 16;
	localparam int LVL_OUT_W   = 10;
	localparam int DISCARD_W   = 10;
	localparam int PHRASE_SLOTS = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] REQ_RX      = 2'd0;
	localparam logic [1:0] REQ_POP     = 2'd1;
	localparam logic [1:0] REQ_DISCARD = 2'd2;
	localparam logic [1:0] REQ_STATS   = 2'd3;

	// passphrase in ASCII, padded with zeros past its end
	localparam logic [7:0] PHRASE_ROM [PHRASE_SLOTS] = '{
		8'h49, 8'h20, 8'h77, 8'h61, 8'h6e, 8'h74, 8'h20, 8'h74,
		8'h6f, 8'h20, 8'h65, 8'h6e, 8'h74, 8'h65, 8'h72, 8'h20,
		8'h41, 8'h6c, 8'h63, 8'h65, 8'h4f, 8'h53, 8'h44, 8'h20,
		8'h73, 8'h65, 8'h74, 8'h75, 8'h70, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		logic [1:0]           req_type;
		logic [PORT_W-1:0]    port;
		logic [7:0]           rx_byte;
		logic                 hw_overflow;
		logic [DISCARD_W-1:0] discard_count;
	} req_t;

	typedef struct packed {
		logic [7:0]           data_byte;
		logic                 data_valid;
		logic                 setup_trigger;
		logic [LVL_OUT_W-1:0] fill_level;
		logic [CNT_W-1:0]     overrun_count;
		logic [CNT_W-1:0]     overflow_count;
		logic [LVL_OUT_W-1:0] max_level;
	} rsp_t;

	function automatic logic [7:0] phrase_char(input logic [MATCH_W-1:0] idx);
		return PHRASE_ROM[idx];
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

/* hw/rtl/uart_rx_fifo_with_passphrase_detect_top.sv */
// Flow: an accepted request reads its per-port context entry, which is used in ST_CTX.
// The result is registered from ST_CTX, or from ST_POP after the byte RAM read for a pop
// that returns a byte; a valid port's context is written back as the result is registered.
// Only ST_IDLE takes requests; ST_CTX and ST_POP wait while the output is full.
// A result waiting in the output register does not stop the next request being taken.
// Reset clears control state, the config mask and the context valid bits (all
// per-port state reads as zero); byte queue contents stay undefined until written.
module uart_rx_fifo_with_passphrase_detect_top #(
	parameter int QUEUE_DEPTH = urxpd_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_PORTS   = urxpd_pkg::NUM_PORTS_DEF,
	parameter int PHRASE_LEN  = urxpd_pkg::PHRASE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [urxpd_pkg::MASK_W-1:0]  cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  urxpd_pkg::req_t               req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output urxpd_pkg::rsp_t               rsp
);

	localparam int PW    = $clog2(QUEUE_DEPTH);
	localparam int LW    = (PW > urxpd_pkg::DISCARD_W) ? PW : urxpd_pkg::DISCARD_W;
	localparam int CIW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int QDEP  = NUM_PORTS * QUEUE_DEPTH;
	localparam int QAW   = (QDEP > 1) ? $clog2(QDEP) : 1;
	localparam int CW    = urxpd_pkg::CNT_W;
	localparam int MW    = urxpd_pkg::MATCH_W;
	localparam int CTX_W = 3 * PW + MW + 2 * CW + 1;

	localparam logic [PW:0]   DEPTH_EXT = (PW + 1)'(QUEUE_DEPTH);
	localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);
	localparam logic [MW-1:0] PHRASE_END = MW'(PHRASE_LEN);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CTX  = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;

	logic [1:0] state_q, state_d;
	urxpd_pkg::req_t req_q;
	logic port_ok_q;
	logic [CIW-1:0] pidx_q;
	logic [urxpd_pkg::MASK_W-1:0] client_mask_q;
	logic rsp_valid_q;
	urxpd_pkg::rsp_t rsp_q, rsp_d;

	logic accept, out_free, finish, pop_hit, q_re, q_we;
	logic [CTX_W-1:0] ctx_rd, ctx_wr;
	logic [7:0] q_rdata;
	logic [QAW-1:0] q_base;

	// current context
	logic [PW-1:0] rp, wp, hwm;
	logic [MW-1:0] mpos;
	logic [CW-1:0] ovr, ovfl;
	logic shell;

	// next context
	logic [PW-1:0] n_rp, n_wp, n_hwm;
	logic [MW-1:0] n_mpos;
	logic [CW-1:0] n_ovr, n_ovfl;
	logic n_shell;

	logic [PW:0] lvl_wide, disc_sum;
	logic [PW-1:0] lvl, lvl_new, lvl_after, nwp, disc_n, rp_disc;
	logic [MW-1:0] pos_eff, pos_nx;
	logic hit, done, keep, full, trig;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign {shell, hwm, ovfl, ovr, mpos, wp, rp} = ctx_rd;
	assign ctx_wr = {n_shell, n_hwm, n_ovfl, n_ovr, n_mpos, n_wp, n_rp};

	assign lvl_wide = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp})
		: ({1'b0, wp} + DEPTH_EXT - {1'b0, rp});
	assign lvl = lvl_wide[PW-1:0];
	assign nwp = (wp == PTR_LAST) ? '0 : wp + PW'(1);
	assign full = (nwp == rp);

	assign pos_eff = (mpos >= PHRASE_END) ? '0 : mpos;
	assign pos_nx  = pos_eff + MW'(1);
	assign hit     = (urxpd_pkg::phrase_char(pos_eff) == req_q.rx_byte);
	assign done    = hit && (pos_nx >= PHRASE_END);
	assign keep    = client_mask_q[req_q.port] || shell;

	// clamp the discard to what the queue holds
	assign disc_n   = (LW'(req_q.discard_count) > LW'(lvl)) ? lvl : PW'(req_q.discard_count);
	assign disc_sum = {1'b0, rp} + {1'b0, disc_n};
	assign rp_disc  = (disc_sum >= DEPTH_EXT) ? PW'(disc_sum - DEPTH_EXT) : disc_sum[PW-1:0];

	assign pop_hit = port_ok_q && (req_q.req_type == urxpd_pkg::REQ_POP) && (rp != wp);

	always_comb begin
		n_rp      = rp;
		n_wp      = wp;
		n_hwm     = hwm;
		n_mpos    = mpos;
		n_ovr     = ovr;
		n_ovfl    = ovfl;
		n_shell   = shell;
		lvl_new   = lvl;
		lvl_after = lvl;
		trig      = 1'b0;
		q_we      = 1'b0;
		case (req_q.req_type)
			urxpd_pkg::REQ_RX: begin
				n_ovfl = req_q.hw_overflow ? urxpd_pkg::sat_inc(ovfl) : ovfl;
				if (done) begin
					n_mpos = '0;
					if (!shell) begin
						n_shell   = 1'b1;
						n_rp      = wp;
						lvl_after = '0;
						trig      = 1'b1;
					end
				end else begin
					n_mpos = hit ? pos_nx : '0;
					if (keep) begin
						if (!full) begin
							q_we    = 1'b1;
							n_wp    = nwp;
							lvl_new = lvl + PW'(1);
						end else begin
							n_ovr = urxpd_pkg::sat_inc(ovr);
						end
						lvl_after = lvl_new;
						if (lvl_new > hwm) begin
							n_hwm = lvl_new;
						end
					end
				end
			end
			urxpd_pkg::REQ_POP: begin
				if (rp != wp) begin
					n_rp      = (rp == PTR_LAST) ? '0 : rp + PW'(1);
					lvl_after = lvl - PW'(1);
				end
			end
			urxpd_pkg::REQ_DISCARD: begin
				n_rp      = rp_disc;
				lvl_after = lvl - disc_n;
			end
			default: begin
				n_ovfl = '0;
				n_hwm  = '0;
			end
		endcase
	end

	always_comb begin
		rsp_d = '0;
		if (port_ok_q) begin
			rsp_d.data_valid     = (state_q == ST_POP);
			rsp_d.data_byte      = (state_q == ST_POP) ? q_rdata : 8'd0;
			rsp_d.setup_trigger  = (req_q.req_type == urxpd_pkg::REQ_RX) && trig;
			rsp_d.fill_level     = urxpd_pkg::LVL_OUT_W'(lvl_after);
			rsp_d.overrun_count  = n_ovr;
			// statistics read reports the values from before the clear
			if (req_q.req_type == urxpd_pkg::REQ_STATS) begin
				rsp_d.overflow_count = ovfl;
				rsp_d.max_level      = urxpd_pkg::LVL_OUT_W'(hwm);
			end else begin
				rsp_d.overflow_count = n_ovfl;
				rsp_d.max_level      = urxpd_pkg::LVL_OUT_W'(n_hwm);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		q_re    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CTX;
				end
			end
			ST_CTX: begin
				if (pop_hit) begin
					q_re    = 1'b1;
					state_d = ST_POP;
				end else if (out_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign q_base = QAW'(pidx_q) * QAW'(QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rsp_valid_q   <= 1'b0;
			client_mask_q <= '0;
			port_ok_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				client_mask_q <= cfg_wdata;
			end
			if (accept) begin
				port_ok_q <= (32'(req.port) < NUM_PORTS);
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			pidx_q <= CIW'(req.port);
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	urxpd_ctx_ram #(
		.DEPTH (NUM_PORTS),
		.AW    (CIW),
		.DW    (CTX_W)
	) u_ctx_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (finish && port_ok_q),
		.waddr  (pidx_q),
		.wdata  (ctx_wr),
		.re     (accept),
		.raddr  (CIW'(req.port)),
		.rdata  (ctx_rd)
	);

	urxpd_queue_ram #(
		.DEPTH (QDEP),
		.AW    (QAW)
	) u_queue_ram (
		.clk   (clk),
		.we    (finish && port_ok_q && q_we && (req_q.req_type == urxpd_pkg::REQ_RX)),
		.waddr (q_base + QAW'(wp)),
		.wdata (req_q.rx_byte),
		.re    (q_re),
		.raddr (q_base + QAW'(rp)),
		.rdata (q_rdata)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/urxpd_queue_ram.sv */
module urxpd_queue_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the last read while no new read is issued
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/urxpd_ctx_ram.sv */
module urxpd_ctx_ram #(
	parameter int DEPTH = 4,
	parameter int AW    = 2,
	parameter int DW    = 72
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// an entry never written reads as its reset value of zero
		if (re) begin
			rdata_q <= vld_q[raddr] ? mem[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule
